// ----- sv/cldm_pkg.sv -----
// Shared types, constants and helpers for the line dip midpoint block.
package cldm_pkg;

    localparam int PIX_W      = 16;
    localparam int IDX_W      = 8;
    localparam int WIDTH_W    = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int MAX_PIXELS_DEF = 128;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FALL_STEP = 2'd0;
    localparam logic [1:0] REG_RISE_STEP = 2'd1;
    localparam logic [1:0] REG_MIN_WIDTH = 2'd2;

    localparam logic [PIX_W-1:0]   FALL_STEP_RST = 16'd8;
    localparam logic [PIX_W-1:0]   RISE_STEP_RST = 16'd5;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 8'd5;

    // Edge tests look back over three earlier pixels
    localparam logic [IDX_W-1:0] HIST_DEPTH = 8'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   fall_step;
        logic [PIX_W-1:0]   rise_step;
        logic [WIDTH_W-1:0] min_width;
    } t_cfg;

    // a - b >= step, exact signed compare
    function automatic logic step_ok(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] step);
        logic signed [PIX_W+1:0] diff;
        begin
            diff = $signed({2'b00, a}) - $signed({2'b00, b});
            return diff >= $signed({2'b00, step});
        end
    endfunction

endpackage

// ----- sv/ccd_line_dip_midpoint.sv -----
// Top level: finds the center of a dark dip in one linear-sensor line.
//
// Usage:
//   Pixel channel: i_pix_valid / o_pix_stall carry one pixel per beat
//   (i_pixel, i_last_pixel). i_last_pixel marks the final pixel of a line.
//   Result channel: o_mid_valid / i_mid_stall carry one beat per line,
//   o_midpoint, issued for the last pixel only; 0 when no valid dip.
//   Config: APB-style port; fall_step at 0x0, rise_step at 0x4,
//   min_width at 0x8. Write only while the block is idle.
// Timing:
//   One pixel per cycle sustained, except while a last pixel waits on a stalled
//   result. A beat lands in the input register; the edge tests and midpoint are
//   computed from it combinationally and the result register loads when it
//   leaves, so o_mid_valid rises once the last pixel's beat leaves the input register.
// Stall:
//   A stalled result holds in the output register; ordinary pixels keep
//   flowing, and only a last pixel waits in the input register until the
//   output register frees, which then backs up o_pix_stall.
// Reset: synchronous, active low; clears line state, restores defaults.
module ccd_line_dip_midpoint #(
    parameter int MAX_PIXELS = cldm_pkg::MAX_PIXELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel channel
    input  logic                             i_pix_valid,
    output logic                             o_pix_stall,
    input  logic [cldm_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_last_pixel,
    // result channel
    output logic                             o_mid_valid,
    input  logic                             i_mid_stall,
    output logic [cldm_pkg::IDX_W-1:0]       o_midpoint,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cldm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cldm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cldm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cldm_pkg::*;

    t_cfg r_cfg;

    // input register
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_last;

    // output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_mid;

    logic             out_free;
    logic             s1_fire;
    logic             in_fire;
    logic             cfg_wr;
    logic [IDX_W-1:0] mid_calc;

    // ---- config registers ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_step <= FALL_STEP_RST;
            r_cfg.rise_step <= RISE_STEP_RST;
            r_cfg.min_width <= MIN_WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FALL_STEP: r_cfg.fall_step <= pwdata[PIX_W-1:0];
                REG_RISE_STEP: r_cfg.rise_step <= pwdata[PIX_W-1:0];
                REG_MIN_WIDTH: r_cfg.min_width <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FALL_STEP: prdata = APB_DATA_W'(r_cfg.fall_step);
            REG_RISE_STEP: prdata = APB_DATA_W'(r_cfg.rise_step);
            REG_MIN_WIDTH: prdata = APB_DATA_W'(r_cfg.min_width);
            default:       prdata = '0;
        endcase
    end

    // ---- handshake ----
    // only a last-pixel beat needs room in the output register
    assign out_free    = !r_out_valid || !i_mid_stall;
    assign s1_fire     = r_s1_valid && (!r_s1_last || out_free);
    assign o_pix_stall = r_s1_valid && !s1_fire;
    assign in_fire     = i_pix_valid && !o_pix_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire || s1_fire) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixel <= i_pixel;
            r_s1_last  <= i_last_pixel;
        end
    end

    // ---- edge tracking ----
    cldm_dip_track #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_fire),
        .i_pixel      (r_s1_pixel),
        .i_last_pixel (r_s1_last),
        .i_cfg        (r_cfg),
        .o_midpoint   (mid_calc)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_mid_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_mid <= mid_calc;
        end
    end

    assign o_mid_valid = r_out_valid;
    assign o_midpoint  = r_out_mid;

endmodule

// ----- sv/cldm_dip_track.sv -----
// Per-line state: pixel history, index, edge phase and edge positions.
module cldm_dip_track #(
    parameter int MAX_PIXELS = cldm_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [cldm_pkg::PIX_W-1:0]  i_pixel,
    input  logic                        i_last_pixel,
    input  cldm_pkg::t_cfg              i_cfg,
    output logic [cldm_pkg::IDX_W-1:0]  o_midpoint
);
    import cldm_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK_FALL = 3'b001,
        PH_SEEK_RISE = 3'b010,
        PH_DONE      = 3'b100
    } t_phase;

    logic [PIX_W-1:0] r_hist [3];
    logic [IDX_W-1:0] r_idx;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_fall_pos;
    logic [IDX_W-1:0] r_rise_pos;

    logic             active;
    logic             fall_hit;
    logic             rise_hit;
    t_phase           ph_mid;
    t_phase           n_phase;
    logic [IDX_W-1:0] n_fall_pos;
    logic [IDX_W-1:0] n_rise_pos;
    logic [IDX_W:0]   pos_sum;
    logic [IDX_W-1:0] pos_gap;

    assign active = (r_idx < IDX_W'(MAX_PIXELS));

    always_comb begin
        fall_hit = active && (r_idx >= HIST_DEPTH) && (r_phase == PH_SEEK_FALL)
                   && step_ok(r_hist[2], r_hist[1], i_cfg.fall_step)
                   && step_ok(r_hist[1], r_hist[0], i_cfg.fall_step)
                   && step_ok(r_hist[0], i_pixel,   i_cfg.fall_step);
        ph_mid     = fall_hit ? PH_SEEK_RISE : r_phase;
        n_fall_pos = fall_hit ? r_idx : r_fall_pos;
        // the pixel that made the falling edge may also make the rising one
        rise_hit = active && (r_idx >= HIST_DEPTH) && (ph_mid == PH_SEEK_RISE)
                   && step_ok(r_hist[1], r_hist[2], i_cfg.rise_step)
                   && step_ok(r_hist[0], r_hist[1], i_cfg.rise_step)
                   && step_ok(i_pixel,   r_hist[0], i_cfg.rise_step);
        n_phase    = rise_hit ? PH_DONE : ph_mid;
        n_rise_pos = rise_hit ? r_idx : r_rise_pos;

        pos_sum = {1'b0, n_fall_pos} + {1'b0, n_rise_pos};
        pos_gap = n_rise_pos - n_fall_pos;
        if ((n_phase == PH_DONE) && (pos_gap >= i_cfg.min_width)) begin
            o_midpoint = pos_sum[IDX_W:1];
        end else begin
            o_midpoint = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last_pixel)) begin
            r_hist[0]  <= '0;
            r_hist[1]  <= '0;
            r_hist[2]  <= '0;
            r_idx      <= '0;
            r_phase    <= PH_SEEK_FALL;
            r_fall_pos <= '0;
            r_rise_pos <= '0;
        end else if (i_fire && active) begin
            r_hist[2]  <= r_hist[1];
            r_hist[1]  <= r_hist[0];
            r_hist[0]  <= i_pixel;
            r_idx      <= r_idx + 1'b1;
            r_phase    <= n_phase;
            r_fall_pos <= n_fall_pos;
            r_rise_pos <= n_rise_pos;
        end
    end

endmodule
